// ===== sv/brbo_pkg.sv =====
// ----------------------------------------------------------------------------
// brbo_pkg
// Shared constants for the byte ring buffer with overwrite: default depth,
// field widths, request codes and status codes.
// ----------------------------------------------------------------------------
package brbo_pkg;

    localparam int DEPTH_DEF = 256;

    localparam int REQ_W  = 3;
    localparam int DATA_W = 8;
    localparam int AMT_W  = 9;
    localparam int ST_W   = 2;
    localparam int FILL_W = 9;

    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DROP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_LESS_DATA = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERWROTE = 2'd2;

endpackage

// ===== sv/brbo_mem.sv =====
// ----------------------------------------------------------------------------
// brbo_mem
// Byte store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brbo_mem
    import brbo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/byte_ring_buffer_overwrite.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite
// Circular byte store with read pointer, write pointer and fill count.
// Requests write, read, peek, drop or clear; a write into a full store
// overwrites the oldest byte.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, data_byte, amount
//   out      output     out_valid / out_ready read_byte, status, fill_level
//
// One request per cycle while the output is not stalled; each result appears in the cycle after its transfer.
// Pointers and count update at the input transfer; the store is read through
// its registered read port into the result stage.
// in_ready is high while the result stage is empty or being drained, so a
// stalled output holds the next request at the input.
// Reset empties the buffer at once; store contents stay undefined.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite
    import brbo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [DATA_W-1:0] data_byte,
    input  logic [AMT_W-1:0]  amount,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_byte,
    output logic [ST_W-1:0]   status,
    output logic [FILL_W-1:0] fill_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > AMT_W) ? CW : AMT_W;
    localparam int SW = ((AW > AMT_W) ? AW : AMT_W) + 1;

    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic              out_valid_reg;
    logic              sel_reg;
    logic [ST_W-1:0]   status_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              in_xfer;
    logic              mem_we;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              sel;
    logic [ST_W-1:0]   st;

    logic [AW-1:0]     rp_inc, wp_inc;
    logic [SW-1:0]     off_sum;
    logic [AW-1:0]     off_addr;
    logic [XW-1:0]     amt_x, cnt_x, cnt_nx;
    logic              full, empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign rp_inc   = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
    assign wp_inc   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign off_sum  = SW'(rp_reg) + SW'(amount);
    assign off_addr = (off_sum >= SW'(DEPTH)) ? AW'(off_sum - SW'(DEPTH)) : AW'(off_sum);
    assign amt_x    = XW'(amount);
    assign cnt_x    = XW'(cnt_reg);
    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);

    always_comb
    begin
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        cnt_next  = cnt_reg;
        mem_we    = 1'b0;
        mem_raddr = rp_reg;
        sel       = 1'b0;
        st        = ST_OK;
        unique case (req_type)
            REQ_WRITE:
            begin
                mem_we  = 1'b1;
                wp_next = wp_inc;
                if (full)
                begin
                    rp_next = rp_inc;
                    st      = ST_OVERWROTE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            REQ_READ:
            begin
                if (empty)
                begin
                    st = ST_LESS_DATA;
                end
                else
                begin
                    sel      = 1'b1;
                    rp_next  = rp_inc;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            REQ_PEEK:
            begin
                if (amt_x >= cnt_x)
                begin
                    st = ST_LESS_DATA;
                end
                else
                begin
                    mem_raddr = off_addr;
                    sel       = 1'b1;
                end
            end
            REQ_DROP:
            begin
                if (amt_x > cnt_x)
                begin
                    rp_next  = '0;
                    wp_next  = '0;
                    cnt_next = '0;
                end
                else
                begin
                    rp_next  = off_addr;
                    cnt_next = CW'(cnt_x - amt_x);
                end
            end
            REQ_CLEAR:
            begin
                rp_next  = '0;
                wp_next  = '0;
                cnt_next = '0;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign cnt_nx = XW'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                rp_reg  <= rp_next;
                wp_reg  <= wp_next;
                cnt_reg <= cnt_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sel_reg    <= sel;
            status_reg <= st;
            fill_reg   <= cnt_nx[FILL_W-1:0];
        end
    end

    brbo_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (in_xfer && mem_we),
        .waddr (wp_reg),
        .wdata (data_byte),
        .re    (in_xfer),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign read_byte  = sel_reg ? mem_rdata : '0;
    assign status     = status_reg;
    assign fill_level = fill_reg;

endmodule

// ===== tb/byte_ring_buffer_overwrite_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_tb
// Self-checking bench for the byte ring buffer with overwrite. Requests go
// in through the valid/ready input channel. A scoreboard keeps its own copy
// of the store, pointers and fill count, works out the result of every input
// transfer, and checks each output transfer in order. The run covers directed
// corner cases and then random traffic under several idle and stall patterns.
// That traffic includes a long output hold-off and a pause until every
// pending result has been taken and checked.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite_tb
    import brbo_pkg::*;
();

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN} stim_mode_t;

    typedef struct packed {
        logic [DATA_W-1:0] rbyte;
        logic [ST_W-1:0]   st;
        logic [FILL_W-1:0] fill;
    } reply_t;

    class ring_scoreboard;
        logic [DATA_W-1:0] store [DEPTH];
        int rd_ptr;
        int wr_ptr;
        int held;
        int errors;
        reply_t pending_replies [$];

        function new();
            foreach (store[i])
                store[i] = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            held   = 0;
            errors = 0;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] data,
                                   logic [AMT_W-1:0] amt);
            reply_t r;
            int off;
            off     = int'(amt);
            r.rbyte = '0;
            r.st    = ST_OK;
            case (req)
                REQ_WRITE:
                begin
                    store[wr_ptr] = data;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    if (held >= DEPTH)
                    begin
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                        r.st   = ST_OVERWROTE;
                    end
                    else
                    begin
                        held++;
                    end
                end
                REQ_READ:
                begin
                    if (held == 0)
                    begin
                        r.st = ST_LESS_DATA;
                    end
                    else
                    begin
                        r.rbyte = store[rd_ptr];
                        rd_ptr  = (rd_ptr + 1) % DEPTH;
                        held--;
                    end
                end
                REQ_PEEK:
                begin
                    if (off >= held)
                        r.st = ST_LESS_DATA;
                    else
                        r.rbyte = store[(rd_ptr + off) % DEPTH];
                end
                REQ_DROP:
                begin
                    if (off > held)
                    begin
                        rd_ptr = 0;
                        wr_ptr = 0;
                        held   = 0;
                    end
                    else
                    begin
                        rd_ptr = (rd_ptr + off) % DEPTH;
                        held   = held - off;
                    end
                end
                REQ_CLEAR:
                begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                    held   = 0;
                end
                default:
                begin
                end
            endcase
            r.fill = held[FILL_W-1:0];
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] rbyte, logic [ST_W-1:0] st,
                                   logic [FILL_W-1:0] fill);
            reply_t exp_r;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result byte %02h status %0d fill %0d",
                             $realtime, rbyte, st, fill);
                return;
            end
            exp_r = pending_replies.pop_front();
            if (exp_r.rbyte !== rbyte || exp_r.st !== st || exp_r.fill !== fill)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                             $realtime, exp_r.rbyte, exp_r.st, exp_r.fill,
                             rbyte, st, fill);
            end
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic [REQ_W-1:0]  req_type   = REQ_WRITE;
    logic [DATA_W-1:0] data_byte  = '0;
    logic [AMT_W-1:0]  amount     = '0;
    logic              out_ready  = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic [DATA_W-1:0] read_byte;
    logic [ST_W-1:0]   status;
    logic [FILL_W-1:0] fill_level;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    ring_scoreboard sb;

    byte_ring_buffer_overwrite #(.DEPTH(DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_byte  (read_byte),
        .status     (status),
        .fill_level (fill_level)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(req_type, data_byte, amount);
            if (out_valid && out_ready)
                sb.check_result(read_byte, status, fill_level);
        end
    end

    task automatic idle_gap();
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drive_item(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data,
                              input logic [AMT_W-1:0] amt);
        in_valid  <= 1'b1;
        req_type  <= req;
        data_byte <= data;
        amount    <= amt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic put(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data,
                       input logic [AMT_W-1:0] amt);
        idle_gap();
        drive_item(req, data, amt);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(negedge clk);
    endtask

    function automatic void pick_item(input stim_mode_t mode, output logic [REQ_W-1:0] req,
                                      output logic [DATA_W-1:0] data,
                                      output logic [AMT_W-1:0] amt);
        int roll;
        roll = $urandom_range(99);
        data = DATA_W'($urandom);
        amt  = AMT_W'($urandom);
        case (mode)
            MODE_FILL:
                req = (roll < 94) ? REQ_WRITE : REQ_PEEK;
            MODE_DRAIN:
            begin
                if (roll < 45)
                    req = REQ_READ;
                else if (roll < 65)
                    req = REQ_PEEK;
                else if (roll < 80)
                    req = REQ_DROP;
                else
                    req = REQ_WRITE;
            end
            default:
            begin
                if (roll < 45)
                    req = REQ_WRITE;
                else if (roll < 63)
                    req = REQ_READ;
                else if (roll < 80)
                    req = REQ_PEEK;
                else if (roll < 90)
                    req = REQ_DROP;
                else if (roll < 93)
                    req = REQ_CLEAR;
                else if (roll < 96)
                    req = REQ_W'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
                else
                    req = REQ_WRITE;
            end
        endcase
        roll = $urandom_range(99);
        if (req == REQ_PEEK)
        begin
            if (sb.held > 0 && roll < 80)
                amt = AMT_W'($urandom_range(sb.held - 1));
            else if (roll < 90)
                amt = AMT_W'(sb.held);
        end
        else if (req == REQ_DROP)
        begin
            if (roll < 60)
                amt = AMT_W'($urandom_range(4));
            else if (roll < 80)
                amt = AMT_W'($urandom_range(sb.held));
            else if (roll < 88)
                amt = AMT_W'(sb.held + 1);
        end
    endfunction

    task automatic run_random(input stim_mode_t mode, input int count);
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] data;
        logic [AMT_W-1:0]  amt;
        repeat (count)
        begin
            idle_gap();
            pick_item(mode, req, data, amt);
            drive_item(req, data, amt);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        put(REQ_READ,  DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_PEEK,  DATA_W'($urandom), 9'd0);
        put(REQ_DROP,  DATA_W'($urandom), 9'd0);
        put(REQ_WRITE, 8'h00,             AMT_W'($urandom));
        put(REQ_WRITE, 8'hFF,             AMT_W'($urandom));
        put(REQ_WRITE, 8'hA5,             AMT_W'($urandom));
        put(REQ_PEEK,  DATA_W'($urandom), 9'd2);
        put(REQ_PEEK,  DATA_W'($urandom), 9'd3);
        put(REQ_PEEK,  DATA_W'($urandom), 9'h1FF);
        put(REQ_READ,  DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_DROP,  DATA_W'($urandom), 9'd1);
        put(REQ_DROP,  DATA_W'($urandom), 9'd256);
        put(REQ_WRITE, 8'h5A,             AMT_W'($urandom));
        put(REQ_WRITE, 8'hC3,             AMT_W'($urandom));
        put(REQ_CLEAR, DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_READ,  DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_SPARE_LO, DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_SPARE_LO + 3'd1, DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_SPARE_HI, DATA_W'($urandom), AMT_W'($urandom));
        put(REQ_WRITE, 8'h3C,             AMT_W'($urandom));
        put(REQ_WRITE, 8'h81,             AMT_W'($urandom));
        put(REQ_DROP,  DATA_W'($urandom), 9'd0);
        put(REQ_DROP,  DATA_W'($urandom), 9'd2);
        put(REQ_PEEK,  DATA_W'($urandom), 9'd256);

        run_random(MODE_FILL, 120);
        hold_left = 80;
        run_random(MODE_FILL, 160);
        run_random(MODE_DRAIN, 30);

        send_idle_pct  = 74;
        recv_stall_pct = 0;
        repeat (8)
        begin
            run_random(MODE_MIX, 20);
            run_random(MODE_DRAIN, 15);
        end

        send_idle_pct  = 0;
        recv_stall_pct = 74;
        run_random(MODE_FILL, 150);
        wait_drained();
        run_random(MODE_FILL, 130);
        run_random(MODE_DRAIN, 30);

        send_idle_pct  = 27;
        recv_stall_pct = 27;
        repeat (8)
        begin
            run_random(MODE_MIX, 20);
            run_random(MODE_DRAIN, 15);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== byte_ring_buffer_overwrite.f =====
sv/brbo_pkg.sv
sv/brbo_mem.sv
sv/byte_ring_buffer_overwrite.sv
tb/byte_ring_buffer_overwrite_tb.sv
